// ===== hw/rtl/ltl_pkg.sv =====
package ltl_pkg;

  // Table sizes.
  localparam int ORIGINS    = 16;
  localparam int MAX_LEASES = 64;

  // Index and field widths.
  localparam int SLOT_W  = ($clog2(ORIGINS) < 1) ? 1 : $clog2(ORIGINS);
  localparam int LIDX_W  = ($clog2(MAX_LEASES) < 1) ? 1 : $clog2(MAX_LEASES);
  localparam int IDX_W   = (LIDX_W > SLOT_W) ? LIDX_W : SLOT_W;
  localparam int OCNT_W  = 5;
  localparam int LCNT_W  = 7;
  localparam int REFS_W  = 7;
  localparam int CFG_W   = 5;
  localparam int KEY_W   = 64;
  localparam int STAMP_W = 64;
  localparam int LID_W   = 32;
  localparam int EVC_W   = 32;
  localparam int STS_W   = 3;
  localparam int OP_W    = 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;
  localparam logic [OP_W-1:0] OP_EPOCH   = 2'd3;

  // Result status codes.
  localparam logic [STS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STS_W-1:0] ST_INVALID    = 3'd1;
  localparam logic [STS_W-1:0] ST_TABLE_FULL = 3'd2;
  localparam logic [STS_W-1:0] ST_LEASE_FULL = 3'd3;
  localparam logic [STS_W-1:0] ST_UNKNOWN    = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             accept;
    logic             disp;
    logic             lfree_chk;
    logic             sscan;
    logic             commit;
    logic             rel_rd;
    logic             rel_chk;
    logic             rel_miss;
    logic             fin;
    logic [IDX_W-1:0] idx;
  } ltl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done_now;
    logic is_acquire;
    logic lfree_hit;
    logic rel_match;
  } ltl_sts_t;

endpackage

// ===== hw/rtl/ltl_ctrl.sv =====
module ltl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ltl_pkg::ltl_sts_t sts,
  output ltl_pkg::ltl_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DISP   = 8'b0000_0010,
    S_LFREE  = 8'b0000_0100,
    S_SSCAN  = 8'b0000_1000,
    S_COMMIT = 8'b0001_0000,
    S_RREAD  = 8'b0010_0000,
    S_RCHK   = 8'b0100_0000,
    S_FIN    = 8'b1000_0000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [ltl_pkg::IDX_W-1:0] idx_r, idx_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.idx   = idx_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        cmd.disp = 1'b1;
        idx_nxt  = '0;
        if (sts.done_now) begin
          state_nxt = S_FIN;
        end else if (sts.is_acquire) begin
          state_nxt = S_LFREE;
        end else begin
          state_nxt = S_RREAD;
        end
      end
      S_LFREE: begin
        cmd.lfree_chk = 1'b1;
        if (sts.lfree_hit) begin
          idx_nxt   = '0;
          state_nxt = S_SSCAN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_SSCAN: begin
        cmd.sscan = 1'b1;
        if (idx_r == ltl_pkg::IDX_W'(ltl_pkg::ORIGINS - 1)) begin
          state_nxt = S_COMMIT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_FIN;
      end
      S_RREAD: begin
        cmd.rel_rd = 1'b1;
        state_nxt  = S_RCHK;
      end
      S_RCHK: begin
        cmd.rel_chk = 1'b1;
        if (sts.rel_match) begin
          state_nxt = S_FIN;
        end else if (idx_r == ltl_pkg::IDX_W'(ltl_pkg::MAX_LEASES - 1)) begin
          cmd.rel_miss = 1'b1;
          state_nxt    = S_FIN;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_RREAD;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and scan index registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== hw/rtl/ltl_dp.sv =====
module ltl_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ltl_pkg::ltl_cmd_t                 cmd,
  output ltl_pkg::ltl_sts_t                 sts,
  input  logic [ltl_pkg::OP_W-1:0]          in_op,
  input  logic [ltl_pkg::KEY_W-1:0]         in_origin_key,
  input  logic                              in_origin_present,
  input  logic [ltl_pkg::LID_W-1:0]         in_lease_number,
  input  logic                              in_lease_is_valid,
  input  logic [ltl_pkg::STAMP_W-1:0]       in_new_epoch,
  input  logic                              cfg_we,
  input  logic [ltl_pkg::CFG_W-1:0]         cfg_data,
  output logic                              out_valid,
  output logic [ltl_pkg::STS_W-1:0]         out_status,
  output logic [ltl_pkg::LID_W-1:0]         out_granted_lease,
  output logic [ltl_pkg::OCNT_W-1:0]        out_origin_count,
  output logic [ltl_pkg::LCNT_W-1:0]        out_lease_count,
  output logic [ltl_pkg::EVC_W-1:0]         out_eviction_count,
  output logic [ltl_pkg::STAMP_W-1:0]       out_epoch_now
);

  // Captured transaction.
  logic [ltl_pkg::OP_W-1:0]    op_r;
  logic [ltl_pkg::KEY_W-1:0]   key_r;
  logic                        present_r;
  logic [ltl_pkg::LID_W-1:0]   id_r;
  logic                        valid_r;
  logic [ltl_pkg::STAMP_W-1:0] epoch_in_r;

  // Control state.
  logic [ltl_pkg::CFG_W-1:0]      max_r;
  logic [ltl_pkg::STAMP_W-1:0]    use_clock_r;
  logic [ltl_pkg::LID_W-1:0]      next_lease_r;
  logic [ltl_pkg::EVC_W-1:0]      evict_r;
  logic [ltl_pkg::STAMP_W-1:0]    epoch_r;
  logic [ltl_pkg::OCNT_W-1:0]     ocnt_r;
  logic [ltl_pkg::LCNT_W-1:0]     lcnt_r;
  logic [ltl_pkg::STS_W-1:0]      status_r;
  logic [ltl_pkg::LID_W-1:0]      granted_r;
  logic [ltl_pkg::ORIGINS-1:0]    su_r;
  logic [ltl_pkg::MAX_LEASES-1:0] lu_r;
  logic                           out_valid_r;

  // Scan results.
  logic [ltl_pkg::LIDX_W-1:0]  lfree_r;
  logic                        hit_f_r, ff_f_r, old_f_r;
  logic [ltl_pkg::SLOT_W-1:0]  hit_idx_r, ff_idx_r, old_idx_r;
  logic [ltl_pkg::STAMP_W-1:0] old_stamp_r;

  // Entry tables, valid only where su_r is set.
  logic [ltl_pkg::KEY_W-1:0]   slot_key_r   [ltl_pkg::ORIGINS];
  logic [ltl_pkg::REFS_W-1:0]  slot_refs_r  [ltl_pkg::ORIGINS];
  logic [ltl_pkg::STAMP_W-1:0] slot_stamp_r [ltl_pkg::ORIGINS];

  // Lease memory, valid only where lu_r is set.
  logic [ltl_pkg::LID_W-1:0]   lmem_id   [ltl_pkg::MAX_LEASES];
  logic [ltl_pkg::SLOT_W-1:0]  lmem_slot [ltl_pkg::MAX_LEASES];
  logic [ltl_pkg::LID_W-1:0]   rd_ident_r;
  logic [ltl_pkg::SLOT_W-1:0]  rd_slot_r;

  // Output registers.
  logic [ltl_pkg::STS_W-1:0]   o_status_r;
  logic [ltl_pkg::LID_W-1:0]   o_granted_r;
  logic [ltl_pkg::OCNT_W-1:0]  o_ocnt_r;
  logic [ltl_pkg::LCNT_W-1:0]  o_lcnt_r;
  logic [ltl_pkg::EVC_W-1:0]   o_evict_r;
  logic [ltl_pkg::STAMP_W-1:0] o_epoch_r;

  logic [ltl_pkg::SLOT_W-1:0]  sa;
  logic [ltl_pkg::LIDX_W-1:0]  li;
  logic [ltl_pkg::KEY_W-1:0]   rk;
  logic [ltl_pkg::REFS_W-1:0]  rr;
  logic [ltl_pkg::STAMP_W-1:0] rs;
  logic                        ru;
  logic [ltl_pkg::OCNT_W-1:0]  lim, cnt2;
  logic                        full, evict, fail, use_old;
  logic [ltl_pkg::SLOT_W-1:0]  tgt;
  logic [ltl_pkg::REFS_W-1:0]  refs_inc, refs_dec;
  logic [ltl_pkg::LID_W-1:0]   lease_nxt;
  logic [ltl_pkg::STS_W-1:0]   disp_status;
  logic                        done_now;
  logic                        rel_bad, lease_full, match;
  logic [ltl_pkg::EVC_W:0]     evc_sum;
  logic [ltl_pkg::EVC_W-1:0]   evc_clear, evc_one;

  // One read port on the entry tables; the address follows the phase.
  assign sa = cmd.sscan  ? cmd.idx[ltl_pkg::SLOT_W-1:0] :
              cmd.commit ? hit_idx_r : rd_slot_r;
  assign li = cmd.idx[ltl_pkg::LIDX_W-1:0];
  assign rk = slot_key_r[sa];
  assign rr = slot_refs_r[sa];
  assign rs = slot_stamp_r[sa];
  assign ru = su_r[sa];

  // Entry limit: zero acts as one, and the table size caps it.
  always_comb begin
    if (max_r == '0) begin
      lim = ltl_pkg::OCNT_W'(1);
    end else if (int'(max_r) > ltl_pkg::ORIGINS) begin
      lim = ltl_pkg::OCNT_W'(ltl_pkg::ORIGINS);
    end else begin
      lim = ltl_pkg::OCNT_W'(max_r);
    end
  end

  // Decisions for the dispatch state of a transaction.
  assign lease_full = (lcnt_r == ltl_pkg::LCNT_W'(ltl_pkg::MAX_LEASES));
  assign rel_bad    = !valid_r || (id_r == '0);
  always_comb begin
    disp_status = ltl_pkg::ST_OK;
    done_now    = 1'b1;
    case (op_r)
      ltl_pkg::OP_ACQUIRE: begin
        if (!present_r) begin
          disp_status = ltl_pkg::ST_INVALID;
        end else if (lease_full) begin
          disp_status = ltl_pkg::ST_LEASE_FULL;
        end else begin
          done_now = 1'b0;
        end
      end
      ltl_pkg::OP_RELEASE: begin
        if (rel_bad) begin
          disp_status = ltl_pkg::ST_INVALID;
        end else begin
          done_now = 1'b0;
        end
      end
      default: begin
        disp_status = ltl_pkg::ST_OK;
      end
    endcase
  end

  assign sts.done_now   = done_now;
  assign sts.is_acquire = (op_r == ltl_pkg::OP_ACQUIRE);
  assign sts.lfree_hit  = !lu_r[li];
  assign match          = lu_r[li] && (rd_ident_r == id_r);
  assign sts.rel_match  = match;

  // Allocation decision at commit, with eviction of the oldest idle entry.
  assign full     = (ocnt_r >= lim);
  assign evict    = !hit_f_r && full && old_f_r;
  assign cnt2     = ocnt_r - ltl_pkg::OCNT_W'(evict);
  assign fail     = !hit_f_r && full && (cnt2 >= lim);
  assign use_old  = evict && (!ff_f_r || (old_idx_r < ff_idx_r));
  assign tgt      = hit_f_r ? hit_idx_r : (use_old ? old_idx_r : ff_idx_r);
  assign refs_inc = (rr == '1) ? rr : rr + 1'b1;
  assign refs_dec = (rr == '0) ? rr : rr - 1'b1;
  assign lease_nxt = (next_lease_r == '1) ? ltl_pkg::LID_W'(1) : next_lease_r + 1'b1;

  // Saturating eviction sums.
  assign evc_sum   = {1'b0, evict_r} + (ltl_pkg::EVC_W + 1)'(ocnt_r);
  assign evc_clear = evc_sum[ltl_pkg::EVC_W] ? '1 : evc_sum[ltl_pkg::EVC_W-1:0];
  assign evc_one   = (evict_r == '1) ? evict_r : evict_r + 1'b1;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r        <= ltl_pkg::CFG_W'(16);
      use_clock_r  <= '0;
      next_lease_r <= ltl_pkg::LID_W'(1);
      evict_r      <= '0;
      epoch_r      <= '0;
      ocnt_r       <= '0;
      lcnt_r       <= '0;
      status_r     <= ltl_pkg::ST_OK;
      granted_r    <= '0;
      su_r         <= '0;
      lu_r         <= '0;
      out_valid_r  <= 1'b0;
      hit_f_r      <= 1'b0;
      ff_f_r       <= 1'b0;
      old_f_r      <= 1'b0;
    end else begin
      out_valid_r <= cmd.fin;
      if (cfg_we) begin
        max_r <= cfg_data;
      end
      if (cmd.accept) begin
        use_clock_r <= use_clock_r + 1'b1;
      end
      // Dispatch: immediate status, scan flags, clear and epoch change.
      if (cmd.disp) begin
        status_r  <= disp_status;
        granted_r <= '0;
        hit_f_r   <= 1'b0;
        ff_f_r    <= 1'b0;
        old_f_r   <= 1'b0;
        if (op_r == ltl_pkg::OP_CLEAR || op_r == ltl_pkg::OP_EPOCH) begin
          evict_r <= evc_clear;
          ocnt_r  <= '0;
          lcnt_r  <= '0;
          su_r    <= '0;
          lu_r    <= '0;
        end
        if (op_r == ltl_pkg::OP_EPOCH) begin
          epoch_r <= epoch_in_r;
        end
      end
      // Entry scan: first key hit, first free slot, oldest idle entry.
      if (cmd.sscan) begin
        if (ru && rk == key_r && !hit_f_r) begin
          hit_f_r <= 1'b1;
        end
        if (!ru && !ff_f_r) begin
          ff_f_r <= 1'b1;
        end
        if (ru && rr == '0 && (!old_f_r || rs < old_stamp_r)) begin
          old_f_r <= 1'b1;
        end
      end
      // Commit of an acquire.
      if (cmd.commit) begin
        if (evict) begin
          su_r[old_idx_r] <= 1'b0;
          evict_r         <= evc_one;
        end
        if (fail) begin
          status_r <= ltl_pkg::ST_TABLE_FULL;
          ocnt_r   <= cnt2;
        end else begin
          su_r[tgt]    <= 1'b1;
          ocnt_r       <= hit_f_r ? ocnt_r : cnt2 + 1'b1;
          lu_r[lfree_r] <= 1'b1;
          lcnt_r       <= lcnt_r + 1'b1;
          granted_r    <= next_lease_r;
          next_lease_r <= lease_nxt;
        end
      end
      // Release of a matching lease.
      if (cmd.rel_chk && match) begin
        lu_r[li] <= 1'b0;
        lcnt_r   <= lcnt_r - 1'b1;
      end
      if (cmd.rel_miss) begin
        status_r <= ltl_pkg::ST_UNKNOWN;
      end
    end
  end

  // Payload registers and entry tables.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r       <= in_op;
      key_r      <= in_origin_key;
      present_r  <= in_origin_present;
      id_r       <= in_lease_number;
      valid_r    <= in_lease_is_valid;
      epoch_in_r <= in_new_epoch;
    end
    if (cmd.lfree_chk) begin
      lfree_r <= li;
    end
    if (cmd.sscan) begin
      if (ru && rk == key_r && !hit_f_r) begin
        hit_idx_r <= sa;
      end
      if (!ru && !ff_f_r) begin
        ff_idx_r <= sa;
      end
      if (ru && rr == '0 && (!old_f_r || rs < old_stamp_r)) begin
        old_idx_r   <= sa;
        old_stamp_r <= rs;
      end
    end
    if (cmd.commit && !fail) begin
      slot_key_r[tgt]   <= key_r;
      slot_refs_r[tgt]  <= hit_f_r ? refs_inc : ltl_pkg::REFS_W'(1);
      slot_stamp_r[tgt] <= use_clock_r;
    end
    if (cmd.rel_chk && match && ru) begin
      slot_refs_r[sa]  <= refs_dec;
      slot_stamp_r[sa] <= use_clock_r;
    end
    if (cmd.fin) begin
      o_status_r  <= status_r;
      o_granted_r <= granted_r;
      o_ocnt_r    <= ocnt_r;
      o_lcnt_r    <= lcnt_r;
      o_evict_r   <= evict_r;
      o_epoch_r   <= epoch_r;
    end
  end

  // Lease memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.commit && !fail) begin
      lmem_id[lfree_r]   <= next_lease_r;
      lmem_slot[lfree_r] <= tgt;
    end
    if (cmd.rel_rd) begin
      rd_ident_r <= lmem_id[li];
      rd_slot_r  <= lmem_slot[li];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = o_status_r;
  assign out_granted_lease  = o_granted_r;
  assign out_origin_count   = o_ocnt_r;
  assign out_lease_count    = o_lcnt_r;
  assign out_eviction_count = o_evict_r;
  assign out_epoch_now      = o_epoch_r;

endmodule

// ===== hw/rtl/lease_table_with_idle_lru_eviction.sv =====
// Clear, epoch change and rejected requests go from dispatch straight to the finish state.
// An acquire walks the lease-use bits to the first free lease slot, then scans all ORIGINS
// entries through the one shared entry-table read port, then commits.
// A release reads each lease slot through the lease memory's registered read port, then
// checks it, up to a match or the last slot. One transaction at a time; out_valid is a one-cycle
// strobe that the receiver cannot stall. Synchronous reset empties both tables at once.
module lease_table_with_idle_lru_eviction (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [ltl_pkg::OP_W-1:0]     in_op,
  input  logic [ltl_pkg::KEY_W-1:0]    in_origin_key,
  input  logic                         in_origin_present,
  input  logic [ltl_pkg::LID_W-1:0]    in_lease_number,
  input  logic                         in_lease_is_valid,
  input  logic                         in_request_ok,
  input  logic [ltl_pkg::STAMP_W-1:0]  in_new_epoch,
  input  logic                         cfg_we,
  input  logic [ltl_pkg::CFG_W-1:0]    cfg_data,
  output logic                         out_valid,
  output logic [ltl_pkg::STS_W-1:0]    out_status,
  output logic [ltl_pkg::LID_W-1:0]    out_granted_lease,
  output logic [ltl_pkg::OCNT_W-1:0]   out_origin_count,
  output logic [ltl_pkg::LCNT_W-1:0]   out_lease_count,
  output logic [ltl_pkg::EVC_W-1:0]    out_eviction_count,
  output logic [ltl_pkg::STAMP_W-1:0]  out_epoch_now
);

  ltl_pkg::ltl_cmd_t cmd;
  ltl_pkg::ltl_sts_t sts;

  // The release outcome flag has no effect on the tables or the result.

  // Sequencer.
  ltl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Tables, counters and result registers.
  ltl_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_op              (in_op),
    .in_origin_key      (in_origin_key),
    .in_origin_present  (in_origin_present),
    .in_lease_number    (in_lease_number),
    .in_lease_is_valid  (in_lease_is_valid),
    .in_new_epoch       (in_new_epoch),
    .cfg_we             (cfg_we),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_granted_lease  (out_granted_lease),
    .out_origin_count   (out_origin_count),
    .out_lease_count    (out_lease_count),
    .out_eviction_count (out_eviction_count),
    .out_epoch_now      (out_epoch_now)
  );

endmodule

// ===== hw/rtl/ltl_chk.sv =====
module ltl_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic [ltl_pkg::STS_W-1:0]   out_status,
  input logic [ltl_pkg::OCNT_W-1:0]  out_origin_count,
  input logic [ltl_pkg::LCNT_W-1:0]  out_lease_count
);

  // An accepted transaction makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("block not busy after an accepted transaction");

  // A result comes out only once the block has finished its work.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while the block is busy");

  // Each transaction gives one result, never two in a row.
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // Status codes and counts stay in range.
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ltl_pkg::ST_UNKNOWN) &&
                  (out_origin_count <= ltl_pkg::OCNT_W'(ltl_pkg::ORIGINS)) &&
                  (out_lease_count <= ltl_pkg::LCNT_W'(ltl_pkg::MAX_LEASES)))
    else $error("result field out of range");

endmodule

bind lease_table_with_idle_lru_eviction ltl_chk u_ltl_chk (.*);
